FILE: rtl/core/bbs_pkg.sv
// Shared types and constants for the beep burst sequencer.
package bbs_pkg;

    // Input item kinds carried on the slave-side tuser bit.
    typedef enum logic
    {
        MODE_TICK    = 1'b0,
        MODE_REQUEST = 1'b1
    } mode_t;

    // Field widths of the stream payloads.
    localparam int COUNT_W  = 8;
    localparam int PERIOD_W = 15;
    localparam int HALF_W   = 12;

    // Largest half-period in ticks; longer requests saturate here.
    localparam logic [HALF_W-1:0] HALF_MAX = 12'hFFF;

    // Register map of the configuration port.
    localparam int                ADDR_W      = 2;
    localparam logic [ADDR_W-1:0] ADDR_ENABLE = 2'd0;

    // Number of holding slots for pending bursts.
    localparam int NUM_SLOTS = 2;

endpackage

FILE: rtl/core/beep_burst_sequencer.sv
// Beep burst sequencer: drives a buzzer level from tick and burst request transfers.
//
// Slave-side stream: every transfer is one item. tuser = 0 marks a tick (one
// TICK_MS interval), tuser = 1 marks a burst request whose tdata carries the
// beep count and the half-period in milliseconds. Every accepted item yields
// exactly one master-side transfer with the buzzer level and the busy flag as
// they stand after the item has been applied.
// An accepted item passes through the input register, then the update logic
// writes the sequencer state and the result register. One item is taken per
// cycle while the receiver takes results; the single update stage with its
// constant-reciprocal divide sets that rate. When the receiver stalls, the
// result register holds and the input register still takes one more item,
// after which tready drops until the result moves. Reset leaves the block
// idle with the buzzer off, both holding slots empty and the enable register
// set. The APB port holds one register, enable, at address 0; the user must
// write it only while no item is in flight, as the block does not enforce it.
module beep_burst_sequencer
    import bbs_pkg::*;
#(
    parameter int TICK_MS = 10
)
(
    input  logic              clk,
    input  logic              rst_n,

    // Input items.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // [7:0] beep_count, [22:8] period_ms, [23] zero
    input  logic              s_tuser,   // [0] mode

    // Results.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [0] buzzer_on, [1] busy_res, [7:2] zero

    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Constant reciprocal for the millisecond to tick conversion.
    localparam int          DIV_SHIFT = PERIOD_W + $clog2(TICK_MS);
    localparam longint      MULT_VAL  = ((64'd1 <<< DIV_SHIFT) + TICK_MS - 1) / TICK_MS;
    localparam logic [16:0] MULT_C    = 17'(MULT_VAL);

    // Configuration register.
    logic enable_reg;

    // Input register.
    logic                in_valid_reg;
    mode_t               in_mode_reg;
    logic [COUNT_W-1:0]  in_count_reg;
    logic [PERIOD_W-1:0] in_period_reg;

    // Sequencer state.
    logic                active_reg,     active_next;
    logic [HALF_W-1:0]   tick_count_reg, tick_count_next;
    logic [COUNT_W-1:0]  beeps_left_reg, beeps_left_next;
    logic [HALF_W-1:0]   half_reg,       half_next;
    logic                drive_reg,      drive_next;
    logic [NUM_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [COUNT_W-1:0]  slot_count_reg  [NUM_SLOTS];
    logic [COUNT_W-1:0]  slot_count_next [NUM_SLOTS];
    logic [HALF_W-1:0]   slot_period_reg [NUM_SLOTS];
    logic [HALF_W-1:0]   slot_period_next[NUM_SLOTS];

    // Result register.
    logic out_valid_reg;

    // Datapath signals.
    logic                advance;
    logic [31:0]         div_prod;
    logic [PERIOD_W-1:0] div_quot;
    logic [HALF_W-1:0]   req_ticks;
    logic [HALF_W:0]     tick_sum;

    // Configuration access; pready is always high.
    assign pready = 1'b1;
    assign prdata = {31'b0, enable_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_ENABLE))
        begin
            enable_reg <= pwdata[0];
        end
    end

    // Handshake: the update stage moves when the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input payload capture.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg   <= mode_t'(s_tuser);
            in_count_reg  <= s_tdata[7:0];
            in_period_reg <= s_tdata[22:8];
        end
    end

    // Half-period in ticks by reciprocal multiply, saturated to the counter range.
    assign div_prod = 32'(in_period_reg) * 32'(MULT_C);
    assign div_quot = PERIOD_W'(div_prod >> DIV_SHIFT);
    assign req_ticks = (div_quot > PERIOD_W'(HALF_MAX)) ? HALF_MAX : div_quot[HALF_W-1:0];

    assign tick_sum = {1'b0, tick_count_reg} + {{HALF_W{1'b0}}, 1'b1};

    // Sequencer update for one item.
    always_comb
    begin
        active_next      = active_reg;
        tick_count_next  = tick_count_reg;
        beeps_left_next  = beeps_left_reg;
        half_next        = half_reg;
        drive_next       = drive_reg;
        slot_valid_next  = slot_valid_reg;
        slot_count_next  = slot_count_reg;
        slot_period_next = slot_period_reg;

        if (advance)
        begin
            if (in_mode_reg == MODE_REQUEST)
            begin
                if (enable_reg)
                begin
                    if (!active_reg)
                    begin
                        active_next     = 1'b1;
                        tick_count_next = '0;
                        beeps_left_next = in_count_reg;
                        half_next       = req_ticks;
                        drive_next      = 1'b1;
                    end
                    else if (!slot_valid_reg[0])
                    begin
                        slot_valid_next[0]  = 1'b1;
                        slot_count_next[0]  = in_count_reg;
                        slot_period_next[0] = req_ticks;
                    end
                    else if (!slot_valid_reg[1])
                    begin
                        slot_valid_next[1]  = 1'b1;
                        slot_count_next[1]  = in_count_reg;
                        slot_period_next[1] = req_ticks;
                    end
                end
            end
            else if (active_reg)
            begin
                if (tick_sum < {1'b0, half_reg})
                begin
                    tick_count_next = tick_sum[HALF_W-1:0];
                end
                else
                begin
                    tick_count_next = '0;
                    if (drive_reg)
                    begin
                        drive_next      = 1'b0;
                        beeps_left_next = beeps_left_reg - 8'd1;
                    end
                    else if (beeps_left_reg != '0)
                    begin
                        drive_next = 1'b1;
                    end
                    else if (slot_valid_reg[0])
                    begin
                        slot_valid_next[0] = 1'b0;
                        beeps_left_next    = slot_count_reg[0];
                        half_next          = slot_period_reg[0];
                    end
                    else if (slot_valid_reg[1])
                    begin
                        slot_valid_next[1] = 1'b0;
                        beeps_left_next    = slot_count_reg[1];
                        half_next          = slot_period_reg[1];
                    end
                    else
                    begin
                        active_next = 1'b0;
                    end
                end
            end
        end
    end

    // Sequencer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            tick_count_reg  <= '0;
            beeps_left_reg  <= '0;
            half_reg        <= '0;
            drive_reg       <= 1'b0;
            slot_valid_reg  <= '0;
            slot_count_reg  <= '{default: '0};
            slot_period_reg <= '{default: '0};
        end
        else
        begin
            active_reg      <= active_next;
            tick_count_reg  <= tick_count_next;
            beeps_left_reg  <= beeps_left_next;
            half_reg        <= half_next;
            drive_reg       <= drive_next;
            slot_valid_reg  <= slot_valid_next;
            slot_count_reg  <= slot_count_next;
            slot_period_reg <= slot_period_next;
        end
    end

    // The result is the state after the update, so it reads straight from the state.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, active_reg, drive_reg};

    // An idle sequencer keeps the buzzer off and holds no pending bursts.
    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (!drive_reg && (slot_valid_reg == '0)))
    else $error("idle sequencer with buzzer on or pending slot");

    // The tick counter stays below the half-period unless it was just cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ((tick_count_reg < half_reg) || (tick_count_reg == '0)))
    else $error("tick counter ran past the half-period");

    // With the result register empty the block must take input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
    else $error("input stalled while result register is empty");

    // A result appears in the cycle after each update.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
    else $error("update without a result");

endmodule

FILE: dv/bbs_checker.sv
// Result checker for the beep burst sequencer: mirrors its state and compares every result.
module bbs_checker
    import bbs_pkg::*;
#(
    parameter int TICK_MS = 10
)
(
    input  logic              clk,
    input  logic              rst_n,

    // Input stream, observed only.
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [23:0]       s_tdata,   // [7:0] beep_count, [22:8] period_ms, [23] zero
    input  logic              s_tuser,   // [0] mode

    // Result stream, observed only.
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,   // [0] buzzer_on, [1] busy_res, [7:2] zero

    // Configuration port, observed only.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,

    // Status for the stimulus side.
    output int                fail_count,
    output int                pending,
    output int                checked,
    output logic              seq_active
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result: the fields sit in the same order as in m_tdata.
    typedef struct packed
    {
        logic busy;
        logic buzzer;
    } sound_t;

    sound_t sound_q[$];

    // Mirror of the sequencer state.
    logic                enable_copy;
    logic [15:0]         tick_cnt;
    logic [COUNT_W-1:0]  beeps_rem;
    logic [HALF_W-1:0]   half_ticks;
    logic                level;
    logic                held_valid [NUM_SLOTS];
    logic [COUNT_W-1:0]  held_count [NUM_SLOTS];
    logic [HALF_W-1:0]   held_half  [NUM_SLOTS];

    // Half-period in ticks, saturating at the largest value the counter can hold.
    function automatic logic [HALF_W-1:0] ms_to_ticks(input logic [PERIOD_W-1:0] ms);
        int unsigned q;
        q = ms / TICK_MS;
        if (q > HALF_MAX)
            q = HALF_MAX;
        return q[HALF_W-1:0];
    endfunction

    // Enabled requests start when idle, else take the first free slot, else are lost.
    function automatic void take_request(input logic [COUNT_W-1:0] cnt,
                                         input logic [HALF_W-1:0] half);
        if (!enable_copy)
            return;
        if (!seq_active)
        begin
            seq_active = 1'b1;
            tick_cnt   = '0;
            beeps_rem  = cnt;
            half_ticks = half;
            level      = 1'b1;
            return;
        end
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (!held_valid[i])
            begin
                held_valid[i] = 1'b1;
                held_count[i] = cnt;
                held_half[i]  = half;
                return;
            end
        end
    endfunction

    // One tick interval: toggle at the half-period, then reload from the slots or stop.
    function automatic void advance_tick();
        if (!seq_active)
            return;
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt < half_ticks)
            return;
        tick_cnt = '0;
        if (level)
        begin
            level     = 1'b0;
            beeps_rem = beeps_rem - 8'd1;
            return;
        end
        if (beeps_rem != 0)
        begin
            level = 1'b1;
            return;
        end
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (held_valid[i])
            begin
                held_valid[i] = 1'b0;
                beeps_rem     = held_count[i];
                half_ticks    = held_half[i];
                return;
            end
        end
        seq_active = 1'b0;
    endfunction

    // Compare each result transfer, then predict from each input transfer.
    always @(posedge clk or negedge rst_n)
    begin
        sound_t got;
        sound_t want;
        if (!rst_n)
        begin
            enable_copy = 1'b1;
            seq_active  = 1'b0;
            tick_cnt    = '0;
            beeps_rem   = '0;
            half_ticks  = '0;
            level       = 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                held_valid[i] = 1'b0;
                held_count[i] = '0;
                held_half[i]  = '0;
            end
            sound_q.delete();
            fail_count = 0;
            checked    = 0;
            pending    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = sound_t'(m_tdata[1:0]);
                if (sound_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual buzzer_on %b busy_res %b",
                             $time, got.buzzer, got.busy);
                end
                else
                begin
                    want = sound_q.pop_front();
                    checked++;
                    if (got.buzzer !== want.buzzer)
                    begin
                        fail_count++;
                        $display("%0t: buzzer_on mismatch, expected %b actual %b",
                                 $time, want.buzzer, got.buzzer);
                    end
                    if (got.busy !== want.busy)
                    begin
                        fail_count++;
                        $display("%0t: busy_res mismatch, expected %b actual %b",
                                 $time, want.busy, got.busy);
                    end
                end
            end

            if (psel && penable && pwrite && pready && paddr == ADDR_ENABLE)
                enable_copy = pwdata[0];

            if (s_tvalid && s_tready)
            begin
                if (mode_t'(s_tuser) == MODE_REQUEST)
                    take_request(s_tdata[7:0], ms_to_ticks(s_tdata[22:8]));
                else
                    advance_tick();
                want.buzzer = level;
                want.busy   = seq_active;
                sound_q.push_back(want);
            end

            pending = sound_q.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
// Stimulus, clock, reset and verdict for the beep burst sequencer testbench.
module tb_top
    import bbs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_MS    = 10;
    localparam int RAND_ITEMS = 80;
    localparam int LONG_HOLD  = 80;
    localparam int RUN_LIMIT  = 500000;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata  = '0;
    logic              s_tuser  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    int   fail_count;
    int   pending;
    int   checked;
    logic seq_active;

    // Stimulus shaping and counters; quiet and long_hold_req are shared between the sender and the receiver.
    logic quiet         = 1'b0;
    logic long_hold_req = 1'b0;
    logic tx_gaps       = 1'b1;
    int   n_ticks       = 0;
    int   n_reqs        = 0;
    int   cycle_cnt     = 0;

    // Receiver state.
    logic long_hold_done = 1'b0;
    logic rx_stalls      = 1'b1;
    int   hold_left      = 0;
    int   stall_left     = 0;
    int   rx_phase       = 0;

    beep_burst_sequencer #(.TICK_MS(TICK_MS)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bbs_checker #(.TICK_MS(TICK_MS)) result_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .seq_active (seq_active)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == RUN_LIMIT)
        begin
            $display("%0t: run stopped at the cycle limit of %0d", $time, RUN_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off that backs up the block.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            rx_phase++;
            if (rx_phase % 150 == 0)
                rx_stalls = ($urandom_range(0, 2) != 0);
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (rx_stalls && !quiet && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 19);
            end
        end
    end

    // Offer one item and wait for its transfer; may open with a random gap.
    task automatic send_item(input mode_t kind, input logic [COUNT_W-1:0] cnt,
                             input logic [PERIOD_W-1:0] per);
        if (tx_gaps && !quiet && $urandom_range(0, 6) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, per, cnt};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (kind == MODE_REQUEST)
            n_reqs++;
        else
            n_ticks++;
    endtask

    // Ticks carry random payload bits, which the block ignores.
    task automatic send_tick();
        send_item(MODE_TICK, COUNT_W'($urandom), PERIOD_W'($urandom));
    endtask

    // Stop offering and wait until every predicted result has arrived.
    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Tick until the sequencer has gone idle.
    task automatic run_until_idle();
        wait_results();
        while (seq_active)
            send_tick();
        wait_results();
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_enable(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ENABLE;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] reg_val;
        int          rand_start;
        int          pick;
        int          n;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Enable on, with junk in the unused register bits.
        reg_val    = $urandom();
        reg_val[0] = 1'b1;
        write_enable(reg_val);

        // Directed: idle tick, zero half-period, slot fill with a zero-count slot,
        // overflow with extreme field values.
        send_tick();
        send_item(MODE_REQUEST, 8'd1, 15'd0);
        send_tick();
        send_tick();
        send_tick();
        send_item(MODE_REQUEST, 8'd2, 15'd25);
        send_item(MODE_REQUEST, 8'd0, 15'd10);
        send_item(MODE_REQUEST, 8'd1, 15'd9);
        send_item(MODE_REQUEST, 8'hFF, 15'h7FFF);
        send_item(MODE_REQUEST, 8'h00, 15'h0000);
        send_tick();
        send_tick();
        run_until_idle();

        // Zero beep count wraps to a 256-beep burst.
        send_item(MODE_REQUEST, 8'd0, 15'd5);
        send_tick();
        send_tick();
        send_tick();
        run_until_idle();

        // Disabled: requests are ignored while a running burst keeps ticking.
        send_item(MODE_REQUEST, 8'd3, 15'd20);
        wait_results();
        reg_val    = $urandom();
        reg_val[0] = 1'b0;
        write_enable(reg_val);
        send_item(MODE_REQUEST, 8'hFF, 15'h7FFF);
        send_item(MODE_REQUEST, 8'h00, 15'h0000);
        repeat (30)
        begin
            if ($urandom_range(0, 1) == 1)
                send_item(MODE_REQUEST, COUNT_W'($urandom), PERIOD_W'($urandom));
            else
                send_tick();
        end
        wait_results();
        reg_val    = $urandom();
        reg_val[0] = 1'b1;
        write_enable(reg_val);

        // Random part: mostly short bursts followed by ticks, some request floods.
        rand_start = n_ticks + n_reqs;
        while (n_ticks + n_reqs - rand_start < RAND_ITEMS)
        begin
            if (!quiet && n_ticks + n_reqs - rand_start >= RAND_ITEMS - 25)
                quiet <= 1'b1;
            if (!long_hold_req && n_ticks + n_reqs - rand_start >= 20)
                long_hold_req <= 1'b1;
            tx_gaps = ($urandom_range(0, 4) != 0);
            pick    = $urandom_range(0, 19);
            if (pick < 15)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(MODE_REQUEST, COUNT_W'($urandom_range(1, 4)),
                                  PERIOD_W'($urandom_range(0, 300)));
                    else
                        send_item(MODE_REQUEST, COUNT_W'($urandom_range(1, 4)),
                                  PERIOD_W'($urandom_range(0, 39)));
                end
                repeat ($urandom_range(0, 50))
                    send_tick();
            end
            else if (pick < 19)
            begin
                repeat ($urandom_range(2, 5))
                    send_item(MODE_REQUEST, COUNT_W'($urandom_range(1, 8)),
                              PERIOD_W'($urandom_range(0, 99)));
                if ($urandom_range(0, 1) == 1)
                    send_tick();
            end
            else
                wait_results();
        end

        // Drain and give the verdict.
        wait_results();
        repeat (8) @(posedge clk);
        $display("Run covered %0d ticks and %0d burst requests; %0d results compared.",
                 n_ticks, n_reqs, checked);
        $display("Included enable off and on, slot overflow, a wrapped zero-count burst, a long hold-off.");
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
